@@ rtl/tssu_pkg.sv @@
// Shared types, codes and default sizes of the thread scheduler and semaphore unit.
package tssu_pkg;

    localparam int THREADS_DEF     = 128;
    localparam int SEMS_DEF        = 4;
    localparam int QUEUE_DEPTH_DEF = 128;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_CREATE   = 3'd1,
        OP_EXIT     = 3'd2,
        OP_JOIN     = 3'd3,
        OP_SEM_INIT = 3'd4,
        OP_SEM_WAIT = 3'd5,
        OP_SEM_POST = 3'd6,
        OP_SEM_DEST = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_BLOCKED = 2'd1,
        TS_EXITED  = 2'd2,
        TS_UNUSED  = 2'd3
    } thread_state_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SEM_DEAD  = 2'd1,
        ST_TOO_MANY  = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR,
        S_JOIN,
        S_WAKE,
        S_POST,
        S_SCAN,
        S_FIN,
        S_RES,
        S_HOLD
    } fsm_t;

endpackage

@@ rtl/thread_scheduler_semaphore_unit_core.sv @@
// Top level: thread table, semaphores and the sequencer with its round robin search.
// A request passes S_CUR, S_FIN and S_RES before its result is offered; a join passes S_JOIN,
// an exit that wakes its joiner S_WAKE, a post that wakes a waiter S_POST, and a search S_SCAN.
// Throughput: one request at a time; the next is taken the cycle after the result is taken.
// Reset: asynchronous, active low; thread 0 ready, no threads created, semaphores dead.
// The thread tables use fill counts and need no clearing pass after reset.
module thread_scheduler_semaphore_unit_core #(
    parameter int THREADS     = tssu_pkg::THREADS_DEF,
    parameter int SEMS        = tssu_pkg::SEMS_DEF,
    parameter int QUEUE_DEPTH = tssu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], target_thread[9:3], sem_index[11:10], init_value[27:12],
    // exit_value[59:28], zero fill[63:60]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status_code[1:0], running_thread[8:2], switched[9], idle[10],
    // new_thread_id[17:11], value_out[49:18], woken_thread[56:50],
    // woken_valid[57], zero fill[63:58]
    output logic [63:0] m_tdata
);

    localparam int TW  = $clog2(THREADS);
    localparam int SW  = (SEMS > 1) ? $clog2(SEMS) : 1;
    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int WD  = SEMS * QUEUE_DEPTH;
    localparam int WW  = $clog2(WD);
    localparam int XW  = ((TW > 7) ? TW : 7) + 1;

    // Memories
    logic [1:0]      ts_mem   [THREADS];
    logic [TW:0]     jn_mem   [THREADS];
    logic [31:0]     ex_mem   [THREADS];
    logic [TW-1:0]   wt_mem   [WD];

    // Semaphore registers
    logic [15:0]     cnt_reg  [SEMS];
    logic [15:0]     cnt_next [SEMS];
    logic            live_reg [SEMS];
    logic            live_next[SEMS];
    logic [QW-1:0]   head_reg [SEMS];
    logic [QW-1:0]   head_next[SEMS];
    logic [QW-1:0]   tail_reg [SEMS];
    logic [QW-1:0]   tail_next[SEMS];
    logic [QW:0]     size_reg [SEMS];
    logic [QW:0]     size_next[SEMS];

    tssu_pkg::fsm_t  state_reg, state_next;
    logic [TW-1:0]   cur_reg, cur_next, before_reg, before_next;
    logic [TW-1:0]   created_reg, created_next;
    logic            ts0_wr_reg, ts0_wr_next, jn0_wr_reg, jn0_wr_next;
    logic [2:0]      op_reg, op_next;
    logic [6:0]      tgt_reg, tgt_next;
    logic [1:0]      sidx_reg, sidx_next;
    logic [15:0]     ival_reg, ival_next;
    logic [31:0]     xval_reg, xval_next;
    logic [1:0]      status_reg, status_next;
    logic [TW-1:0]   newid_reg, newid_next;
    logic [31:0]     vout_reg, vout_next;
    logic [TW-1:0]   woken_reg, woken_next;
    logic            wvalid_reg, wvalid_next;
    logic [TW-1:0]   scan_c_reg, scan_c_next;
    logic [TW:0]     scan_n_reg, scan_n_next;
    logic            pend_reg, pend_next;
    logic [63:0]     out_reg, out_next;
    logic            mval_reg, mval_next;

    // Memory ports
    logic [TW-1:0]   ts_raddr, ts_raddr_reg, ts_waddr;
    logic [1:0]      ts_q, ts_wdata;
    logic            ts_we;
    logic [TW:0]     jn_q, jn_wdata;
    logic [TW-1:0]   jn_waddr;
    logic            jn_we;
    logic [31:0]     ex_q;
    logic            ex_we;
    logic [WW-1:0]   wt_raddr, wt_waddr;
    logic [TW-1:0]   wt_q;
    logic            wt_we;

    // Decoded working values
    logic [1:0]      ts_eff;
    logic            jn_valid;
    logic [TW-1:0]   tgt_t, scan_nxt;
    logic [SW-1:0]   s_t;
    logic            s_in_range, sem_ok;
    logic [QW-1:0]   new_tail, new_head;
    logic [2:0]      eff_op;

    assign s_tready = (state_reg == tssu_pkg::S_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = out_reg;

    // Thread state as seen through the fill count and the entry 0 write flag
    always_comb
    begin
        if (ts_raddr_reg > created_reg)
            ts_eff = tssu_pkg::TS_UNUSED;
        else if (ts_raddr_reg == '0 && !ts0_wr_reg)
            ts_eff = tssu_pkg::TS_READY;
        else
            ts_eff = ts_q;
    end

    assign jn_valid   = (cur_reg != '0 || jn0_wr_reg) && jn_q[TW];
    assign tgt_t      = TW'(tgt_reg);
    assign s_t        = SW'(sidx_reg);
    assign s_in_range = ({6'd0, sidx_reg} < 8'(SEMS));
    assign sem_ok     = s_in_range && live_reg[s_t];
    assign scan_nxt   = (scan_c_reg >= created_reg) ? '0 : scan_c_reg + 1'b1;
    assign new_tail   = (tail_reg[s_t] == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg[s_t] + 1'b1;
    assign new_head   = (head_reg[s_t] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg[s_t] + 1'b1;
    assign wt_raddr   = WW'(s_t) * WW'(QUEUE_DEPTH) + WW'(head_reg[s_t]);

    // Ops that need a running thread fall back to a plain search
    always_comb
    begin
        eff_op = op_reg;
        if (ts_eff != tssu_pkg::TS_READY &&
            (op_reg == tssu_pkg::OP_EXIT || op_reg == tssu_pkg::OP_JOIN ||
             op_reg == tssu_pkg::OP_SEM_WAIT))
            eff_op = tssu_pkg::OP_TICK;
    end

    // Sequencer: next state, register updates and memory controls
    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        before_next  = before_reg;
        created_next = created_reg;
        ts0_wr_next  = ts0_wr_reg;
        jn0_wr_next  = jn0_wr_reg;
        op_next      = op_reg;
        tgt_next     = tgt_reg;
        sidx_next    = sidx_reg;
        ival_next    = ival_reg;
        xval_next    = xval_reg;
        status_next  = status_reg;
        newid_next   = newid_reg;
        vout_next    = vout_reg;
        woken_next   = woken_reg;
        wvalid_next  = wvalid_reg;
        scan_c_next  = scan_c_reg;
        scan_n_next  = scan_n_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        mval_next    = mval_reg;
        for (int i = 0; i < SEMS; i++)
        begin
            cnt_next[i]  = cnt_reg[i];
            live_next[i] = live_reg[i];
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            size_next[i] = size_reg[i];
        end
        ts_raddr = cur_reg;
        ts_we    = 1'b0;
        ts_waddr = cur_reg;
        ts_wdata = tssu_pkg::TS_READY;
        jn_we    = 1'b0;
        jn_waddr = cur_reg;
        jn_wdata = '0;
        ex_we    = 1'b0;
        wt_we    = 1'b0;
        wt_waddr = WW'(s_t) * WW'(QUEUE_DEPTH) + WW'(new_tail);

        case (state_reg)
            tssu_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tdata[2:0];
                    tgt_next    = s_tdata[9:3];
                    sidx_next   = s_tdata[11:10];
                    ival_next   = s_tdata[27:12];
                    xval_next   = s_tdata[59:28];
                    before_next = cur_reg;
                    status_next = tssu_pkg::ST_OK;
                    newid_next  = '0;
                    vout_next   = '0;
                    woken_next  = '0;
                    wvalid_next = 1'b0;
                    scan_c_next = cur_reg;
                    scan_n_next = '0;
                    pend_next   = 1'b0;
                    state_next  = tssu_pkg::S_CUR;
                end
            end
            tssu_pkg::S_CUR:
            begin
                state_next = tssu_pkg::S_FIN;
                case (eff_op)
                    tssu_pkg::OP_TICK:
                        state_next = tssu_pkg::S_SCAN;
                    tssu_pkg::OP_CREATE:
                    begin
                        if ({1'b0, created_reg} + 1'b1 >= (TW + 1)'(THREADS))
                            status_next = tssu_pkg::ST_TOO_MANY;
                        else
                        begin
                            created_next = created_reg + 1'b1;
                            newid_next   = created_reg + 1'b1;
                            ts_we        = 1'b1;
                            ts_waddr     = created_reg + 1'b1;
                            ts_wdata     = tssu_pkg::TS_READY;
                            jn_we        = 1'b1;
                            jn_waddr     = created_reg + 1'b1;
                            jn_wdata     = '0;
                        end
                    end
                    tssu_pkg::OP_EXIT:
                    begin
                        ts_we    = 1'b1;
                        ts_wdata = tssu_pkg::TS_EXITED;
                        ex_we    = 1'b1;
                        if (cur_reg == '0)
                            ts0_wr_next = 1'b1;
                        if (jn_valid)
                        begin
                            woken_next  = jn_q[TW-1:0];
                            wvalid_next = 1'b1;
                            state_next  = tssu_pkg::S_WAKE;
                        end
                        else
                            state_next = tssu_pkg::S_SCAN;
                    end
                    tssu_pkg::OP_JOIN:
                    begin
                        ts_raddr   = tgt_t;
                        state_next = tssu_pkg::S_JOIN;
                    end
                    tssu_pkg::OP_SEM_INIT:
                    begin
                        if (!s_in_range)
                            status_next = tssu_pkg::ST_SEM_DEAD;
                        else
                        begin
                            live_next[s_t] = 1'b1;
                            cnt_next[s_t]  = ival_reg;
                            head_next[s_t] = '0;
                            tail_next[s_t] = QW'(QUEUE_DEPTH - 1);
                            size_next[s_t] = '0;
                        end
                    end
                    tssu_pkg::OP_SEM_WAIT:
                    begin
                        if (!sem_ok)
                            status_next = tssu_pkg::ST_SEM_DEAD;
                        else if (cnt_reg[s_t] != '0)
                            cnt_next[s_t] = cnt_reg[s_t] - 1'b1;
                        else if (size_reg[s_t] >= (QW + 1)'(QUEUE_DEPTH))
                            status_next = tssu_pkg::ST_SATURATED;
                        else
                        begin
                            tail_next[s_t] = new_tail;
                            size_next[s_t] = size_reg[s_t] + 1'b1;
                            wt_we          = 1'b1;
                            ts_we          = 1'b1;
                            ts_wdata       = tssu_pkg::TS_BLOCKED;
                            if (cur_reg == '0)
                                ts0_wr_next = 1'b1;
                            state_next     = tssu_pkg::S_SCAN;
                        end
                    end
                    tssu_pkg::OP_SEM_POST:
                    begin
                        if (!sem_ok)
                            status_next = tssu_pkg::ST_SEM_DEAD;
                        else if (size_reg[s_t] != '0)
                        begin
                            head_next[s_t] = new_head;
                            size_next[s_t] = size_reg[s_t] - 1'b1;
                            state_next     = tssu_pkg::S_POST;
                        end
                        else if (cnt_reg[s_t] >= tssu_pkg::COUNT_MAX)
                            status_next = tssu_pkg::ST_SATURATED;
                        else
                            cnt_next[s_t] = cnt_reg[s_t] + 1'b1;
                    end
                    default:
                    begin
                        if (!sem_ok)
                            status_next = tssu_pkg::ST_SEM_DEAD;
                        else
                            live_next[s_t] = 1'b0;
                    end
                endcase
            end
            tssu_pkg::S_JOIN:
            begin
                state_next = tssu_pkg::S_FIN;
                if ((XW'(tgt_reg) >= XW'(THREADS)) || (XW'(tgt_reg) > XW'(created_reg)) ||
                    (tgt_t == cur_reg) || (ts_eff == tssu_pkg::TS_UNUSED))
                    state_next = tssu_pkg::S_FIN;
                else if (ts_eff == tssu_pkg::TS_EXITED)
                    vout_next = ex_q;
                else
                begin
                    ts_we    = 1'b1;
                    ts_wdata = tssu_pkg::TS_BLOCKED;
                    if (cur_reg == '0)
                        ts0_wr_next = 1'b1;
                    jn_we    = 1'b1;
                    jn_waddr = tgt_t;
                    jn_wdata = {1'b1, cur_reg};
                    if (tgt_t == '0)
                        jn0_wr_next = 1'b1;
                    state_next = tssu_pkg::S_SCAN;
                end
            end
            tssu_pkg::S_WAKE:
            begin
                ts_we    = 1'b1;
                ts_waddr = woken_reg;
                ts_wdata = tssu_pkg::TS_READY;
                if (woken_reg == '0)
                    ts0_wr_next = 1'b1;
                state_next = tssu_pkg::S_SCAN;
            end
            tssu_pkg::S_POST:
            begin
                ts_we       = 1'b1;
                ts_waddr    = wt_q;
                ts_wdata    = tssu_pkg::TS_READY;
                if (wt_q == '0)
                    ts0_wr_next = 1'b1;
                woken_next  = wt_q;
                wvalid_next = 1'b1;
                cur_next    = wt_q;
                state_next  = tssu_pkg::S_FIN;
            end
            tssu_pkg::S_SCAN:
            begin
                // Check the entry read last cycle while the next one is read
                if (pend_reg && ts_eff == tssu_pkg::TS_READY)
                begin
                    cur_next   = ts_raddr_reg;
                    state_next = tssu_pkg::S_FIN;
                end
                else if (scan_n_reg <= {1'b0, created_reg})
                begin
                    ts_raddr    = scan_nxt;
                    scan_c_next = scan_nxt;
                    scan_n_next = scan_n_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                else
                    state_next = tssu_pkg::S_FIN;
            end
            tssu_pkg::S_FIN:
            begin
                ts_raddr   = cur_reg;
                state_next = tssu_pkg::S_RES;
            end
            tssu_pkg::S_RES:
            begin
                out_next = {6'd0, wvalid_reg, 7'(woken_reg), vout_reg, 7'(newid_reg),
                            (ts_eff != tssu_pkg::TS_READY), (cur_reg != before_reg),
                            7'(cur_reg), status_reg};
                mval_next  = 1'b1;
                state_next = tssu_pkg::S_HOLD;
            end
            tssu_pkg::S_HOLD:
            begin
                if (m_tready)
                begin
                    mval_next  = 1'b0;
                    state_next = tssu_pkg::S_IDLE;
                end
            end
            default:
                state_next = tssu_pkg::S_IDLE;
        endcase
    end

    // Memories, written and read with registered data
    always_ff @(posedge clk)
    begin
        if (ts_we)
            ts_mem[ts_waddr] <= ts_wdata;
        ts_q <= ts_mem[ts_raddr];
        if (jn_we)
            jn_mem[jn_waddr] <= jn_wdata;
        jn_q <= jn_mem[cur_reg];
        if (ex_we)
            ex_mem[cur_reg] <= xval_reg;
        ex_q <= ex_mem[tgt_t];
        if (wt_we)
            wt_mem[wt_waddr] <= cur_reg;
        wt_q <= wt_mem[wt_raddr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tssu_pkg::S_IDLE;
            cur_reg      <= '0;
            created_reg  <= '0;
            ts0_wr_reg   <= 1'b0;
            jn0_wr_reg   <= 1'b0;
            mval_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            ts_raddr_reg <= '0;
            for (int i = 0; i < SEMS; i++)
            begin
                cnt_reg[i]  <= '0;
                live_reg[i] <= 1'b0;
                head_reg[i] <= '0;
                tail_reg[i] <= QW'(QUEUE_DEPTH - 1);
                size_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            created_reg  <= created_next;
            ts0_wr_reg   <= ts0_wr_next;
            jn0_wr_reg   <= jn0_wr_next;
            mval_reg     <= mval_next;
            pend_reg     <= pend_next;
            ts_raddr_reg <= ts_raddr;
            for (int i = 0; i < SEMS; i++)
            begin
                cnt_reg[i]  <= cnt_next[i];
                live_reg[i] <= live_next[i];
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                size_reg[i] <= size_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        before_reg <= before_next;
        op_reg     <= op_next;
        tgt_reg    <= tgt_next;
        sidx_reg   <= sidx_next;
        ival_reg   <= ival_next;
        xval_reg   <= xval_next;
        status_reg <= status_next;
        newid_reg  <= newid_next;
        vout_reg   <= vout_next;
        woken_reg  <= woken_next;
        wvalid_reg <= wvalid_next;
        scan_c_reg <= scan_c_next;
        scan_n_reg <= scan_n_next;
        out_reg    <= out_next;
    end

`ifndef ASSERT_OFF
    // A request is never taken while a result is still on offer.
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("request accepted while a result is pending");
    // The running thread is always one of the created ids.
    assert property (@(posedge clk) disable iff (!rst_n) cur_reg <= created_reg)
        else $error("running thread beyond created range");
    // The search never visits more entries than thread 0 and the created threads together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tssu_pkg::S_SCAN) |-> (scan_n_reg <= {1'b0, created_reg} + 1'b1))
        else $error("round robin search overran");
    // A result shows up only after the result stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == tssu_pkg::S_RES))
        else $error("result raised outside the result stage");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the thread scheduler and semaphore unit, checked against a predictor.
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0]  status_code;
    logic [6:0]  running_thread;
    logic        switched;
    logic        idle;
    logic [6:0]  new_thread_id;
    logic [31:0] value_out;
    logic [6:0]  woken_thread;
    logic        woken_valid;
} sched_result_t;

// Scheduler predictor and the queue of results it has worked out.
class sched_scoreboard;
    localparam int NTHR = tssu_pkg::THREADS_DEF;
    localparam int NSEM = tssu_pkg::SEMS_DEF;
    localparam int QDEP = tssu_pkg::QUEUE_DEPTH_DEF;

    tssu_pkg::thread_state_t thr_state[NTHR];
    logic [7:0]    joiner[NTHR];     // bit 7 valid, low bits joiner id
    logic [31:0]   exit_val[NTHR];
    int            created;
    int            cur;
    logic [15:0]   count[NSEM];
    bit            live[NSEM];
    int            wq[NSEM][$];
    sched_result_t pending[$];
    int            mismatches;
    int            checked;

    function new();
        for (int i = 0; i < NTHR; i++)
        begin
            thr_state[i] = tssu_pkg::TS_UNUSED;
            joiner[i] = '0;
            exit_val[i] = '0;
        end
        thr_state[0] = tssu_pkg::TS_READY;
        created = 0;
        cur = 0;
        for (int s = 0; s < NSEM; s++)
        begin
            count[s] = '0;
            live[s] = 1'b0;
            wq[s].delete();
        end
        mismatches = 0;
        checked = 0;
    endfunction

    function bit cur_ready();
        return thr_state[cur] == tssu_pkg::TS_READY;
    endfunction

    function int wait_len(int s);
        return wq[s].size();
    endfunction

    // Round robin search from the thread after the running one.
    function void next_ready();
        int c;
        c = cur;
        for (int n = 0; n <= created && n < NTHR; n++)
        begin
            c++;
            if (c > created || c >= NTHR)
                c = 0;
            if (thr_state[c] == tssu_pkg::TS_READY)
            begin
                cur = c;
                return;
            end
        end
    endfunction

    function void note_request(tssu_pkg::opcode_t op_in, int tgt, int s, logic [15:0] ival,
                               logic [31:0] xval);
        sched_result_t r;
        tssu_pkg::opcode_t op;
        int prev;
        int id;
        r = '0;
        op = op_in;
        prev = cur;
        if (!cur_ready() && (op == tssu_pkg::OP_EXIT || op == tssu_pkg::OP_JOIN ||
                             op == tssu_pkg::OP_SEM_WAIT))
            op = tssu_pkg::OP_TICK;
        case (op)
            tssu_pkg::OP_TICK: next_ready();
            tssu_pkg::OP_CREATE:
                if (created + 1 >= NTHR)
                    r.status_code = tssu_pkg::ST_TOO_MANY;
                else
                begin
                    created++;
                    thr_state[created] = tssu_pkg::TS_READY;
                    joiner[created] = '0;
                    r.new_thread_id = 7'(created);
                end
            tssu_pkg::OP_EXIT:
            begin
                thr_state[cur] = tssu_pkg::TS_EXITED;
                exit_val[cur] = xval;
                if (joiner[cur][7])
                begin
                    id = int'(joiner[cur][6:0]);
                    thr_state[id] = tssu_pkg::TS_READY;
                    r.woken_thread = 7'(id);
                    r.woken_valid = 1'b1;
                end
                next_ready();
            end
            tssu_pkg::OP_JOIN:
                if (!(tgt > created || tgt == cur || thr_state[tgt] == tssu_pkg::TS_UNUSED))
                begin
                    if (thr_state[tgt] == tssu_pkg::TS_EXITED)
                        r.value_out = exit_val[tgt];
                    else
                    begin
                        thr_state[cur] = tssu_pkg::TS_BLOCKED;
                        joiner[tgt] = {1'b1, 7'(cur)};
                        next_ready();
                    end
                end
            tssu_pkg::OP_SEM_INIT:
            begin
                live[s] = 1'b1;
                count[s] = ival;
                wq[s].delete();
            end
            tssu_pkg::OP_SEM_WAIT:
                if (!live[s])
                    r.status_code = tssu_pkg::ST_SEM_DEAD;
                else if (count[s] > 0)
                    count[s]--;
                else if (wq[s].size() >= QDEP)
                    r.status_code = tssu_pkg::ST_SATURATED;
                else
                begin
                    wq[s].push_back(cur);
                    thr_state[cur] = tssu_pkg::TS_BLOCKED;
                    next_ready();
                end
            tssu_pkg::OP_SEM_POST:
                if (!live[s])
                    r.status_code = tssu_pkg::ST_SEM_DEAD;
                else if (wq[s].size() > 0)
                begin
                    id = wq[s].pop_front();
                    thr_state[id] = tssu_pkg::TS_READY;
                    r.woken_thread = 7'(id);
                    r.woken_valid = 1'b1;
                    cur = id;
                end
                else if (count[s] == tssu_pkg::COUNT_MAX)
                    r.status_code = tssu_pkg::ST_SATURATED;
                else
                    count[s]++;
            default:
                if (!live[s])
                    r.status_code = tssu_pkg::ST_SEM_DEAD;
                else
                    live[s] = 1'b0;
        endcase
        r.running_thread = 7'(cur);
        r.switched = (cur != prev);
        r.idle = (thr_state[cur] != tssu_pkg::TS_READY);
        pending.push_back(r);
    endfunction

    function string res_str(sched_result_t r);
        return $sformatf("st=%0d run=%0d sw=%0d idle=%0d new=%0d val=%h wk=%0d/%0d",
                         r.status_code, r.running_thread, r.switched, r.idle,
                         r.new_thread_id, r.value_out, r.woken_thread, r.woken_valid);
    endfunction

    function void check_result(logic [63:0] data);
        sched_result_t act;
        sched_result_t exp_r;
        act.status_code    = data[1:0];
        act.running_thread = data[8:2];
        act.switched       = data[9];
        act.idle           = data[10];
        act.new_thread_id  = data[17:11];
        act.value_out      = data[49:18];
        act.woken_thread   = data[56:50];
        act.woken_valid    = data[57];
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result %h", data);
            return;
        end
        exp_r = pending.pop_front();
        if (act !== exp_r || data[63:58] !== 6'd0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d expected %s, got %s",
                         checked, res_str(exp_r), res_str(act));
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    sched_scoreboard sb;
    int sent;
    int burst_left;
    int op_hist[8];

    thread_scheduler_semaphore_unit_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stalls in runs, with long stretches of no stalling.
    initial
    begin
        int mode;
        m_tready = 1'b0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Send one request; bursts of back-to-back requests with random gaps.
    // Valid stays high between requests of a burst and drops only for a gap.
    task automatic send_request(tssu_pkg::opcode_t op, int tgt, int s, logic [15:0] ival,
                                logic [31:0] xval);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        sb.note_request(op, tgt, s, ival, xval);
        op_hist[op]++;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, xval, ival, 2'(s), 7'(tgt), op};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Pick an opcode weighted toward the calls that move threads around.
    task automatic random_request();
        int w;
        int s;
        int tgt;
        tssu_pkg::opcode_t op;
        logic [15:0] ival;
        w = $urandom_range(0, 99);
        s = $urandom_range(0, 3);
        if (w < 12)      op = tssu_pkg::OP_TICK;
        else if (w < 26) op = (sb.created < 40 || w < 16) ? tssu_pkg::OP_CREATE
                                                          : tssu_pkg::OP_TICK;
        else if (w < 36) op = tssu_pkg::OP_EXIT;
        else if (w < 48) op = tssu_pkg::OP_JOIN;
        else if (w < 56) op = tssu_pkg::OP_SEM_INIT;
        else if (w < 72) op = tssu_pkg::OP_SEM_WAIT;
        else if (w < 92) op = tssu_pkg::OP_SEM_POST;
        else             op = tssu_pkg::OP_SEM_DEST;
        // Never leave everything blocked for long: post to wake the waiters or create a thread.
        if (!sb.cur_ready() && w < 60)
            op = (w < 40) ? tssu_pkg::OP_SEM_POST : tssu_pkg::OP_CREATE;
        if ($urandom_range(0, 3) == 0)
            tgt = $urandom_range(0, 127);
        else
            tgt = $urandom_range(0, sb.created);
        case ($urandom_range(0, 5))
            0: ival = 16'hFFFF;
            1: ival = 16'hFFFE;
            2: ival = 16'($urandom);
            default: ival = 16'($urandom_range(0, 3));
        endcase
        send_request(op, tgt, s, ival, $urandom);
    endtask

    initial
    begin
        int wait_cycles;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sent = 0;
        burst_left = 0;
        foreach (op_hist[i]) op_hist[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: dead semaphores, joins of self and unused threads, saturation.
        send_request(tssu_pkg::OP_SEM_WAIT, 0, 3, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_POST, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_DEST, 0, 2, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_JOIN, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_JOIN, 127, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_INIT, 0, 3, 16'hFFFF, 32'd0);
        send_request(tssu_pkg::OP_SEM_POST, 0, 3, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_WAIT, 0, 3, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_INIT, 0, 1, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_CREATE, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_CREATE, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_JOIN, 1, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_EXIT, 0, 0, 16'd0, 32'hFFFF_FFFF);
        send_request(tssu_pkg::OP_TICK, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_JOIN, 1, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_WAIT, 0, 1, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_WAIT, 0, 1, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_WAIT, 0, 1, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_TICK, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_POST, 0, 1, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_INIT, 0, 1, 16'd5, 32'd0);
        send_request(tssu_pkg::OP_SEM_DEST, 0, 1, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_EXIT, 0, 0, 16'd0, 32'h8000_0001);

        // Random traffic; then fill the thread table to its limit and a queue to its depth.
        repeat (800) random_request();
        while (sb.created < 127)
            send_request(tssu_pkg::OP_CREATE, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_CREATE, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_INIT, 0, 2, 16'd0, 32'd0);
        for (int k = 0; k < 200 && sb.wait_len(2) < 128; k++)
        begin
            if (sb.cur_ready())
                send_request(tssu_pkg::OP_SEM_WAIT, 0, 2, 16'd0, 32'd0);
            else
                send_request(tssu_pkg::OP_TICK, 0, 0, 16'd0, 32'd0);
        end
        send_request(tssu_pkg::OP_SEM_POST, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_INIT, 0, 0, 16'd0, 32'd0);
        send_request(tssu_pkg::OP_SEM_WAIT, 0, 0, 16'd0, 32'd0);
        repeat (200) random_request();
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        $write("Sent %0d events (tick %0d, create %0d, exit %0d, join %0d, ",
               sent, op_hist[0], op_hist[1], op_hist[2], op_hist[3]);
        $display("init %0d, wait %0d, post %0d, destroy %0d).",
                 op_hist[4], op_hist[5], op_hist[6], op_hist[7]);
        $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
                 sb.checked, sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("Timeout waiting for results.");
        $display("Regression FAIL");
        $finish;
    end
endmodule
